/* sv/hvfr_pkg.sv */
// shared definitions for the heightmap vertex and face raise block
// sequencer program codes, control word layout and microcode table
// no dependencies
package hvfr_pkg;

    localparam int MAX_FACE_COLS_DEF = 63;
    localparam int MAX_FACE_ROWS_DEF = 63;

    localparam logic [1:0] CMD_RAISE_VERTEX = 2'd0;
    localparam logic [1:0] CMD_RAISE_FACE   = 2'd1;
    localparam logic [1:0] CMD_READ_VERTEX  = 2'd2;

    localparam logic CFG_FACE_COLS = 1'b0;
    localparam logic CFG_FACE_ROWS = 1'b1;

    localparam logic [1:0] CRN_0 = 2'd0;
    localparam logic [1:0] CRN_1 = 2'd1;
    localparam logic [1:0] CRN_2 = 2'd2;
    localparam logic [1:0] CRN_3 = 2'd3;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_V_RD   = 5'd0;
    localparam pc_t PC_V_CAP  = 5'd1;
    localparam pc_t PC_V_LVL  = 5'd2;
    localparam pc_t PC_V_WR   = 5'd3;
    localparam pc_t PC_R_RD   = 5'd4;
    localparam pc_t PC_R_CAP  = 5'd5;
    localparam pc_t PC_F_RD0  = 5'd6;
    localparam pc_t PC_F_RD1  = 5'd7;
    localparam pc_t PC_F_RD2  = 5'd8;
    localparam pc_t PC_F_RD3  = 5'd9;
    localparam pc_t PC_F_CAP  = 5'd10;
    localparam pc_t PC_F_LVL  = 5'd11;
    localparam pc_t PC_F_WR0  = 5'd12;
    localparam pc_t PC_F_WR1  = 5'd13;
    localparam pc_t PC_F_WR2  = 5'd14;
    localparam pc_t PC_F_WR3  = 5'd15;
    localparam pc_t PC_DONE_0 = 5'd16;
    localparam pc_t PC_DONE_Z = 5'd17;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [1:0] ak;
        logic       cap;
        logic [1:0] zk;
        logic       lvl;
        logic       one;
        logic       done;
        logic       hz;
        pc_t        nxt;
    } ctrl_t;

    function automatic ctrl_t hvfr_rom(input pc_t pc);
        ctrl_t w;
        w = '0;
        unique case (pc)
            PC_V_RD:
            begin
                w.rd = 1'b1; w.ak = CRN_3; w.nxt = PC_V_CAP;
            end
            PC_V_CAP:
            begin
                w.cap = 1'b1; w.zk = CRN_3; w.nxt = PC_V_LVL;
            end
            PC_V_LVL:
            begin
                w.lvl = 1'b1; w.one = 1'b1; w.nxt = PC_V_WR;
            end
            PC_V_WR:
            begin
                w.wr = 1'b1; w.ak = CRN_3; w.zk = CRN_3; w.nxt = PC_DONE_0;
            end
            PC_R_RD:
            begin
                w.rd = 1'b1; w.ak = CRN_3; w.nxt = PC_R_CAP;
            end
            PC_R_CAP:
            begin
                w.cap = 1'b1; w.zk = CRN_3; w.nxt = PC_DONE_Z;
            end
            PC_F_RD0:
            begin
                w.rd = 1'b1; w.ak = CRN_0; w.nxt = PC_F_RD1;
            end
            PC_F_RD1:
            begin
                w.rd = 1'b1; w.ak = CRN_1; w.cap = 1'b1; w.zk = CRN_0; w.nxt = PC_F_RD2;
            end
            PC_F_RD2:
            begin
                w.rd = 1'b1; w.ak = CRN_2; w.cap = 1'b1; w.zk = CRN_1; w.nxt = PC_F_RD3;
            end
            PC_F_RD3:
            begin
                w.rd = 1'b1; w.ak = CRN_3; w.cap = 1'b1; w.zk = CRN_2; w.nxt = PC_F_CAP;
            end
            PC_F_CAP:
            begin
                w.cap = 1'b1; w.zk = CRN_3; w.nxt = PC_F_LVL;
            end
            PC_F_LVL:
            begin
                w.lvl = 1'b1; w.nxt = PC_F_WR0;
            end
            PC_F_WR0:
            begin
                w.wr = 1'b1; w.ak = CRN_0; w.zk = CRN_0; w.nxt = PC_F_WR1;
            end
            PC_F_WR1:
            begin
                w.wr = 1'b1; w.ak = CRN_1; w.zk = CRN_1; w.nxt = PC_F_WR2;
            end
            PC_F_WR2:
            begin
                w.wr = 1'b1; w.ak = CRN_2; w.zk = CRN_2; w.nxt = PC_F_WR3;
            end
            PC_F_WR3:
            begin
                w.wr = 1'b1; w.ak = CRN_3; w.zk = CRN_3; w.nxt = PC_DONE_0;
            end
            PC_DONE_Z:
            begin
                w.done = 1'b1; w.hz = 1'b1; w.nxt = PC_DONE_Z;
            end
            default:
            begin
                w.done = 1'b1; w.nxt = PC_DONE_0;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/hvfr_seq.sv */
// microcode sequencer: step counter, control table lookup, done handling
// depends on hvfr_pkg
module hvfr_seq
    import hvfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  pc_t   entry,
    input  logic  hold,
    output ctrl_t ctrl,
    output logic  busy
);

    pc_t  pc_reg, pc_next;
    logic busy_reg, busy_next;

    assign ctrl = busy_reg ? hvfr_rom(pc_reg) : '0;
    assign busy = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = entry;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ctrl.done)
            begin
                if (!hold)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                pc_next = ctrl.nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_DONE_0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

/* sv/heightmap_vertex_face_raise.sv */
// heightmap vertex and face raise on a 16-bit height grid; uses hvfr_pkg and hvfr_seq
// the next command is accepted the cycle after the result is registered; a result
// waiting under out_stall holds the sequencer in its done step, and commands never
// overlap, as corner reads and writes go one at a time through memory
// reset clears control and starts a zeroing pass over all 2**(row bits + col bits)
// memory words (4096 at default size), during which input stalls
module heightmap_vertex_face_raise
    import hvfr_pkg::*;
#(
    parameter int MAX_FACE_COLS = MAX_FACE_COLS_DEF,
    parameter int MAX_FACE_ROWS = MAX_FACE_ROWS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [5:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [15:0] delta,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        height,
    output logic               status
);

    localparam int RW    = $clog2(MAX_FACE_ROWS + 1);
    localparam int CW    = $clog2(MAX_FACE_COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    logic [5:0]         face_cols_reg, face_rows_reg;
    logic [5:0]         row_reg, col_reg;
    logic signed [15:0] delta_reg;
    logic               err_reg;
    logic [15:0]        z_reg [4];
    logic [15:0]        lo_reg, hi_reg;
    logic [15:0]        mem_q_reg;
    logic               clr_active_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               out_valid_reg;
    logic [15:0]        height_reg;
    logic               status_reg;

    logic [15:0] mem [DEPTH];

    logic [5:0]    eff_cols, eff_rows;
    logic          in_accept, vtx_ok, face_ok, entry_err;
    pc_t           entry;
    ctrl_t         ctrl;
    logic          busy, hold, out_load;
    logic [6:0]    r_sum, c_sum;
    logic [31:0]   r_ext, c_ext;
    logic [AW-1:0] addr, waddr;
    logic          we;
    logic [15:0]   wdata, alu_out, z_sel, min4, max4;

    function automatic logic [15:0] level(input logic [15:0] z, input logic signed [15:0] d,
                                          input logic [15:0] lo, input logic [15:0] hi);
        logic signed [17:0] dx, s, lo_s, hi_s, lo_d, hi_d, n;
        logic               pos;
        dx   = 18'(d);
        s    = $signed({2'b00, z}) + dx;
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        lo_d = lo_s + dx;
        hi_d = hi_s + dx;
        pos  = !d[15] && (d != 16'sd0);
        if (pos)
        begin
            n = (s < hi_s) ? s : hi_s;
            n = (n > lo_d) ? n : lo_d;
        end
        else
        begin
            n = (s > lo_s) ? s : lo_s;
            n = (n < hi_d) ? n : hi_d;
        end
        priority if (n < 18'sd0)
        begin
            return 16'd0;
        end
        else if (n > 18'sd65535)
        begin
            return 16'hFFFF;
        end
        else
        begin
            return n[15:0];
        end
    endfunction

    assign eff_cols = (32'(face_cols_reg) > MAX_FACE_COLS) ? 6'(MAX_FACE_COLS) : face_cols_reg;
    assign eff_rows = (32'(face_rows_reg) > MAX_FACE_ROWS) ? 6'(MAX_FACE_ROWS) : face_rows_reg;

    assign in_stall  = busy | clr_active_reg;
    assign in_accept = in_valid && !in_stall;

    assign vtx_ok  = (row <= eff_rows) && (col <= eff_cols);
    assign face_ok = (row < eff_rows) && (col < eff_cols);

    always_comb
    begin
        unique case (cmd)
            CMD_RAISE_VERTEX:
            begin
                entry_err = !vtx_ok;
                entry     = vtx_ok ? PC_V_RD : PC_DONE_0;
            end
            CMD_RAISE_FACE:
            begin
                entry_err = !face_ok;
                entry     = face_ok ? PC_F_RD0 : PC_DONE_0;
            end
            CMD_READ_VERTEX:
            begin
                entry_err = !vtx_ok;
                entry     = vtx_ok ? PC_R_RD : PC_DONE_0;
            end
            default:
            begin
                entry_err = 1'b1;
                entry     = PC_DONE_0;
            end
        endcase
    end

    assign hold     = out_valid_reg && out_stall;
    assign out_load = ctrl.done && !hold;

    hvfr_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .entry (entry),
        .hold  (hold),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // corner offsets: 0 (r+1,c) 1 (r+1,c+1) 2 (r,c+1) 3 (r,c)
    assign r_sum = {1'b0, row_reg} + 7'(!ctrl.ak[1]);
    assign c_sum = {1'b0, col_reg} + 7'(ctrl.ak[0] ^ ctrl.ak[1]);
    assign r_ext = 32'(r_sum);
    assign c_ext = 32'(c_sum);
    assign addr  = {r_ext[RW-1:0], c_ext[CW-1:0]};

    always_comb
    begin
        min4 = z_reg[0];
        max4 = z_reg[0];
        for (int k = 1; k < 4; k++)
        begin
            if (z_reg[k] < min4)
            begin
                min4 = z_reg[k];
            end
            if (z_reg[k] > max4)
            begin
                max4 = z_reg[k];
            end
        end
    end

    assign z_sel   = z_reg[ctrl.zk];
    assign alu_out = level(z_sel, delta_reg, lo_reg, hi_reg);

    assign we    = clr_active_reg | ctrl.wr;
    assign waddr = clr_active_reg ? clr_cnt_reg : addr;
    assign wdata = clr_active_reg ? 16'd0 : alu_out;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd)
        begin
            mem_q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            row_reg   <= row;
            col_reg   <= col;
            delta_reg <= delta;
            err_reg   <= entry_err;
        end
        if (ctrl.cap)
        begin
            z_reg[ctrl.zk] <= mem_q_reg;
        end
        if (ctrl.lvl)
        begin
            lo_reg <= ctrl.one ? z_reg[3] : min4;
            hi_reg <= ctrl.one ? z_reg[3] : max4;
        end
        if (out_load)
        begin
            height_reg <= ctrl.hz ? z_reg[3] : 16'd0;
            status_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_cols_reg  <= 6'd63;
            face_rows_reg  <= 6'd63;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_FACE_COLS: face_cols_reg <= cfg_wdata;
                    CFG_FACE_ROWS: face_rows_reg <= cfg_wdata;
                endcase
            end
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign status    = status_reg;

endmodule
